/* sv/dsch_pkg.sv */
`default_nettype none
package dsch_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_BLOCK_BITS  = 16;
    localparam int DEF_TAG_BITS    = 8;

    localparam int TRAVEL_W = 40;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_ENQ  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DONE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLR  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOP  = 2'd2;

    typedef enum logic [1:0] {
        POL_FCFS  = 2'd0,
        POL_SSTF  = 2'd1,
        POL_CSCAN = 2'd2,
        POL_ALT   = 2'd3   // behaves as FCFS
    } t_policy;

    typedef struct packed {
        logic    load;     // read data valid this cycle
        logic    first;    // entry 0, the oldest
        t_policy policy;
    } t_pick_ctl;

endpackage
`default_nettype wire

/* sv/disk_request_scheduler_core.sv */
`default_nettype none
// Disk request scheduler: queues block requests and issues one at a time
// to the disk under FCFS, shortest seek, or circular scan order.
//
// Input: an action (enqueue / done / clear travel) with block, write_op and
// tag, transferred at a clock edge where start is high and busy is low.
// Config: i_cfg_we writes the 2-bit policy; do it only while idle.
// Output: exactly one result per transfer, shown for one cycle with
// o_strobe; the receiver cannot stall, so results are never held.
//
// Flow: with no dispatch (disk busy or queue empty) the result strobes
// the cycle after the transfer and busy stays low, so one item per cycle.
// With a dispatch, the pending table (N entries, N up to QUEUE_DEPTH)
// is scanned one entry per cycle through the single read port of the
// table RAM; after the scan the result strobes. Removal then closes the
// gap in arrival order, one entry moved per cycle, and busy stays high
// until it is done, so no new item is taken before then.
//
// Reset (sync, active low) empties the queue, frees the disk, zeroes head
// position and travel, and selects FCFS. Table contents need no clearing.
module disk_request_scheduler_core
    import dsch_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int BLOCK_BITS  = DEF_BLOCK_BITS,
    parameter int TAG_BITS    = DEF_TAG_BITS,
    localparam int IDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_wdata,
    input  wire logic [ACTION_W-1:0]   i_action,
    input  wire logic [BLOCK_BITS-1:0] i_block,
    input  wire logic                  i_write_op,
    input  wire logic [TAG_BITS-1:0]   i_tag,
    output logic                       o_strobe,
    output logic      [STATUS_W-1:0]   o_status,
    output logic                       o_dispatched,
    output logic      [BLOCK_BITS-1:0] o_issue_block,
    output logic                       o_issue_write,
    output logic      [TAG_BITS-1:0]   o_issue_tag,
    output logic                       o_completed,
    output logic      [TAG_BITS-1:0]   o_completed_tag,
    output logic      [CNT_W-1:0]      o_pending_count,
    output logic      [TRAVEL_W-1:0]   o_head_travel
);

    localparam int ENT_W = BLOCK_BITS + 1 + TAG_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,   // read every pending entry, track best
        S_DISP,   // issue the pick, move head, add travel
        S_SHIFT   // compact the table over the picked entry
    } t_state;

    t_state                r_state;
    t_policy               r_policy;
    logic [CNT_W-1:0]      r_total;
    logic [BLOCK_BITS-1:0] r_head;
    logic                  r_disk_busy;
    logic [TAG_BITS-1:0]   r_cur_tag;
    logic [TRAVEL_W-1:0]   r_travel;

    // read sequencer shared by scan and compaction
    logic [CNT_W-1:0]      r_rd_idx;
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_rd_pidx;
    logic [CNT_W-1:0]      r_lim;

    // result registers
    logic                  r_strobe;
    logic [STATUS_W-1:0]   r_status;
    logic                  r_disp;
    logic [BLOCK_BITS-1:0] r_iblk;
    logic                  r_iwr;
    logic [TAG_BITS-1:0]   r_itag;
    logic                  r_comp;
    logic [TAG_BITS-1:0]   r_ctag;

    logic                  accept;
    logic                  q_full;
    logic [STATUS_W-1:0]   act_status;
    logic                  act_comp, act_dbusy, act_clr, act_enq;
    logic [CNT_W-1:0]      act_total;

    logic                  mem_we, mem_re;
    logic [IDX_W-1:0]      mem_waddr;
    logic [ENT_W-1:0]      mem_wdata, mem_rdata;
    logic [CNT_W-1:0]      rd_lim;

    t_pick_ctl             pick_ctl;
    logic [BLOCK_BITS-1:0] pk_blk;
    logic                  pk_wr;
    logic [TAG_BITS-1:0]   pk_tag;
    logic [IDX_W-1:0]      pk_idx;
    logic [BLOCK_BITS-1:0] pk_dist;
    logic [TRAVEL_W:0]     travel_sum;
    logic [TRAVEL_W-1:0]   n_travel;
    logic [CNT_W-1:0]      pk_next;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign q_full = (r_total >= CNT_W'(QUEUE_DEPTH));

    // effect of the action itself, before any dispatch
    always_comb begin
        act_status = STAT_NOP;
        act_comp   = 1'b0;
        act_dbusy  = r_disk_busy;
        act_clr    = 1'b0;
        act_enq    = 1'b0;
        act_total  = r_total;
        case (i_action)
            ACT_ENQ: begin
                if (q_full) begin
                    act_status = STAT_FULL;
                end else begin
                    act_status = STAT_OK;
                    act_enq    = 1'b1;
                    act_total  = r_total + CNT_W'(1);
                end
            end
            ACT_DONE: begin
                if (r_disk_busy) begin
                    act_status = STAT_OK;
                    act_comp   = 1'b1;
                    act_dbusy  = 1'b0;
                end
            end
            ACT_CLR: begin
                act_status = STAT_OK;
                act_clr    = 1'b1;
            end
            default: begin
                act_status = STAT_NOP;
            end
        endcase
    end

    // table RAM port control
    assign rd_lim    = (r_state == S_SHIFT) ? r_lim : r_total;
    assign mem_re    = ((r_state == S_SCAN) || (r_state == S_SHIFT)) && (r_rd_idx < rd_lim);
    assign mem_we    = (accept && act_enq) || ((r_state == S_SHIFT) && r_rd_vld);
    assign mem_waddr = (r_state == S_SHIFT) ? (r_rd_pidx - IDX_W'(1))
                                            : r_total[IDX_W-1:0];
    assign mem_wdata = (r_state == S_SHIFT) ? mem_rdata : {i_block, i_write_op, i_tag};

    dsch_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENT_W),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (mem_rdata)
    );

    assign pick_ctl.load   = (r_state == S_SCAN) && r_rd_vld;
    assign pick_ctl.first  = (r_rd_pidx == '0);
    assign pick_ctl.policy = r_policy;

    dsch_pick #(
        .BLOCK_BITS (BLOCK_BITS),
        .TAG_BITS   (TAG_BITS),
        .IDX_W      (IDX_W)
    ) u_pick (
        .i_clk  (i_clk),
        .i_ctl  (pick_ctl),
        .i_head (r_head),
        .i_idx  (r_rd_pidx),
        .i_blk  (mem_rdata[ENT_W-1 -: BLOCK_BITS]),
        .i_wr   (mem_rdata[TAG_BITS]),
        .i_tag  (mem_rdata[TAG_BITS-1:0]),
        .o_blk  (pk_blk),
        .o_wr   (pk_wr),
        .o_tag  (pk_tag),
        .o_idx  (pk_idx)
    );

    // seek distance and saturating travel total
    assign pk_dist    = (pk_blk >= r_head) ? (pk_blk - r_head) : (r_head - pk_blk);
    assign travel_sum = {1'b0, r_travel} + (TRAVEL_W + 1)'(pk_dist);
    assign n_travel   = travel_sum[TRAVEL_W] ? '1 : travel_sum[TRAVEL_W-1:0];
    assign pk_next    = CNT_W'(pk_idx) + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_policy    <= POL_FCFS;
            r_total     <= '0;
            r_head      <= '0;
            r_disk_busy <= 1'b0;
            r_cur_tag   <= '0;
            r_travel    <= '0;
            r_rd_vld    <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_policy <= t_policy'(i_cfg_wdata);
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_status    <= act_status;
                        r_comp      <= act_comp;
                        r_ctag      <= act_comp ? r_cur_tag : '0;
                        r_total     <= act_total;
                        r_disk_busy <= act_dbusy;
                        if (act_clr) begin
                            r_travel <= '0;
                        end
                        if (!act_dbusy && (act_total != '0)) begin
                            r_state  <= S_SCAN;
                            r_rd_idx <= '0;
                            r_rd_vld <= 1'b0;
                            r_strobe <= 1'b0;
                        end else begin
                            r_strobe <= 1'b1;
                            r_disp   <= 1'b0;
                            r_iblk   <= '0;
                            r_iwr    <= 1'b0;
                            r_itag   <= '0;
                        end
                    end else begin
                        r_strobe <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_strobe <= 1'b0;
                    if (mem_re) begin
                        r_rd_idx  <= r_rd_idx + CNT_W'(1);
                        r_rd_pidx <= r_rd_idx[IDX_W-1:0];
                        r_rd_vld  <= 1'b1;
                    end else begin
                        r_rd_vld  <= 1'b0;
                    end
                    // last entry is being folded in at this edge
                    if (r_rd_vld && (r_rd_idx == r_total)) begin
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_strobe    <= 1'b1;
                    r_disp      <= 1'b1;
                    r_iblk      <= pk_blk;
                    r_iwr       <= pk_wr;
                    r_itag      <= pk_tag;
                    r_travel    <= n_travel;
                    r_head      <= pk_blk;
                    r_cur_tag   <= pk_tag;
                    r_disk_busy <= 1'b1;
                    r_total     <= r_total - CNT_W'(1);
                    r_rd_vld    <= 1'b0;
                    if (pk_next < r_total) begin
                        r_state  <= S_SHIFT;
                        r_rd_idx <= pk_next;
                        r_lim    <= r_total;
                    end else begin
                        r_state  <= S_IDLE;
                    end
                end
                S_SHIFT: begin
                    r_strobe <= 1'b0;
                    // read entry j, write it to j-1 in the next cycle
                    if (mem_re) begin
                        r_rd_idx  <= r_rd_idx + CNT_W'(1);
                        r_rd_pidx <= r_rd_idx[IDX_W-1:0];
                        r_rd_vld  <= 1'b1;
                    end else begin
                        r_rd_vld  <= 1'b0;
                    end
                    if (r_rd_vld && (r_rd_idx == r_lim)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_strobe <= 1'b0;
                    r_state  <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_dispatched    = r_disp;
    assign o_issue_block   = r_iblk;
    assign o_issue_write   = r_iwr;
    assign o_issue_tag     = r_itag;
    assign o_completed     = r_comp;
    assign o_completed_tag = r_ctag;
    assign o_pending_count = r_total;
    assign o_head_travel   = r_travel;

`ifndef SYNTH
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(QUEUE_DEPTH))
        else $error("pending count above queue depth");

    a_disp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_dispatched) |-> r_disk_busy)
        else $error("dispatch without disk marked busy");

    a_shift_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_rd_vld) |-> (r_rd_pidx != '0))
        else $error("compaction write below entry 0");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_total != '0 && !r_disk_busy))
        else $error("scan with empty queue or busy disk");
`endif

endmodule
`default_nettype wire

/* sv/dsch_mem.sv */
`default_nettype none
module dsch_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 25,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* sv/dsch_pick.sv */
`default_nettype none
module dsch_pick
    import dsch_pkg::*;
#(
    parameter int BLOCK_BITS = 16,
    parameter int TAG_BITS   = 8,
    parameter int IDX_W      = 4
) (
    input  wire logic                  i_clk,
    input  wire t_pick_ctl             i_ctl,
    input  wire logic [BLOCK_BITS-1:0] i_head,
    input  wire logic [IDX_W-1:0]      i_idx,
    input  wire logic [BLOCK_BITS-1:0] i_blk,
    input  wire logic                  i_wr,
    input  wire logic [TAG_BITS-1:0]   i_tag,
    output logic      [BLOCK_BITS-1:0] o_blk,
    output logic                       o_wr,
    output logic      [TAG_BITS-1:0]   o_tag,
    output logic      [IDX_W-1:0]      o_idx
);

    // candidate A: oldest (FCFS), nearest (SSTF) or nearest forward (C-SCAN)
    logic [BLOCK_BITS-1:0] r_a_blk, r_a_dist;
    logic                  r_a_wr, r_a_vld;
    logic [TAG_BITS-1:0]   r_a_tag;
    logic [IDX_W-1:0]      r_a_idx;
    // candidate B: lowest block, C-SCAN wrap
    logic [BLOCK_BITS-1:0] r_b_blk;
    logic                  r_b_wr;
    logic [TAG_BITS-1:0]   r_b_tag;
    logic [IDX_W-1:0]      r_b_idx;

    logic                  fwd;
    logic [BLOCK_BITS-1:0] ent_dist;
    logic                  take_a, take_b, use_b;

    assign fwd      = (i_blk >= i_head);
    assign ent_dist = fwd ? (i_blk - i_head) : (i_head - i_blk);

    always_comb begin
        case (i_ctl.policy)
            POL_SSTF:  take_a = i_ctl.first || (ent_dist < r_a_dist);
            POL_CSCAN: take_a = fwd && (i_ctl.first || !r_a_vld || (ent_dist < r_a_dist));
            default:   take_a = i_ctl.first;
        endcase
    end

    assign take_b = i_ctl.first || (i_blk < r_b_blk);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            if (take_a) begin
                r_a_blk  <= i_blk;
                r_a_dist <= ent_dist;
                r_a_wr   <= i_wr;
                r_a_tag  <= i_tag;
                r_a_idx  <= i_idx;
                r_a_vld  <= 1'b1;
            end else if (i_ctl.first) begin
                r_a_vld  <= 1'b0;
            end
            if (take_b) begin
                r_b_blk <= i_blk;
                r_b_wr  <= i_wr;
                r_b_tag <= i_tag;
                r_b_idx <= i_idx;
            end
        end
    end

    assign use_b = (i_ctl.policy == POL_CSCAN) && !r_a_vld;
    assign o_blk = use_b ? r_b_blk : r_a_blk;
    assign o_wr  = use_b ? r_b_wr  : r_a_wr;
    assign o_tag = use_b ? r_b_tag : r_a_tag;
    assign o_idx = use_b ? r_b_idx : r_a_idx;

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import dsch_pkg::*;

    // Block sizes match the defaults of the core instance below.
    localparam int QDEPTH    = DEF_QUEUE_DEPTH;
    localparam int BLK_W     = DEF_BLOCK_BITS;
    localparam int TAG_W     = DEF_TAG_BITS;
    localparam int CNT_W     = $clog2(QDEPTH + 1);

    // Action code 3 has no meaning in the core: no effect, status NOP,
    // but a pick may still follow it.
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

    localparam logic [TRAVEL_W-1:0] TRAVEL_MAX = '1;

    // A dispatch scans the table and then closes the gap. After the last
    // result we give the core this long to finish compacting before
    // touching the policy register.
    localparam int SETTLE_CYCLES = 2 * QDEPTH + 8;

    // The test drives about 2000 items, which fit well inside this many
    // cycles even at the worst case per item and the longest input gap.
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 250;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BLK_W-1:0]    block;
        logic                wr;
        logic [TAG_W-1:0]    tag;
    } t_req_item;

    typedef struct packed {
        logic [BLK_W-1:0] block;
        logic             wr;
        logic [TAG_W-1:0] tag;
    } t_waiting_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                dispatched;
        logic [BLK_W-1:0]    issue_block;
        logic                issue_write;
        logic [TAG_W-1:0]    issue_tag;
        logic                completed;
        logic [TAG_W-1:0]    completed_tag;
        logic [CNT_W-1:0]    pending_count;
        logic [TRAVEL_W-1:0] head_travel;
    } t_sched_result;

    // ------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                start        = 1'b0;
    logic                busy;
    logic                i_cfg_we     = 1'b0;
    logic [1:0]          i_cfg_wdata  = '0;
    logic [ACTION_W-1:0] i_action     = '0;
    logic [BLK_W-1:0]    i_block      = '0;
    logic                i_write_op   = 1'b0;
    logic [TAG_W-1:0]    i_tag        = '0;
    logic                o_strobe;
    logic [STATUS_W-1:0] o_status;
    logic                o_dispatched;
    logic [BLK_W-1:0]    o_issue_block;
    logic                o_issue_write;
    logic [TAG_W-1:0]    o_issue_tag;
    logic                o_completed;
    logic [TAG_W-1:0]    o_completed_tag;
    logic [CNT_W-1:0]    o_pending_count;
    logic [TRAVEL_W-1:0] o_head_travel;

    // ------------------------------------------------------------------
    // Scheduler shadow state, updated once per accepted transfer
    // ------------------------------------------------------------------
    t_policy             sched_policy = POL_FCFS;
    t_waiting_req        waiting_reqs[$];      // arrival order, [0] oldest
    logic [BLK_W-1:0]    shadow_head  = '0;
    logic                disk_on      = 1'b0;
    logic [TAG_W-1:0]    cur_tag      = '0;
    logic [TRAVEL_W-1:0] travel       = '0;

    t_req_item           queued_actions[$];    // waiting to be driven
    t_sched_result       expected_outcomes[$]; // waiting for o_strobe

    bit                  took_item = 1'b0;     // transfer at the last rising edge
    bit                  idle_ok   = 1'b1;     // random input gaps allowed
    int                  gap_left  = 0;
    int                  errors    = 0;
    int                  cycles    = 0;

    disk_request_scheduler_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_action        (i_action),
        .i_block         (i_block),
        .i_write_op      (i_write_op),
        .i_tag           (i_tag),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_dispatched    (o_dispatched),
        .o_issue_block   (o_issue_block),
        .o_issue_write   (o_issue_write),
        .o_issue_tag     (o_issue_tag),
        .o_completed     (o_completed),
        .o_completed_tag (o_completed_tag),
        .o_pending_count (o_pending_count),
        .o_head_travel   (o_head_travel)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int seek_dist(int a, int b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Index of the next request to serve under the current policy.
    function automatic int pick_next();
        int  best;
        int  lo;
        int  fd;
        int  d;
        bit  have_fwd;
        best     = 0;
        lo       = 0;
        fd       = 0;
        have_fwd = 1'b0;
        if (sched_policy == POL_SSTF) begin
            // strict < keeps the oldest of equally near requests
            fd = seek_dist(waiting_reqs[0].block, shadow_head);
            for (int i = 1; i < waiting_reqs.size(); i++) begin
                d = seek_dist(waiting_reqs[i].block, shadow_head);
                if (d < fd) begin
                    fd   = d;
                    best = i;
                end
            end
        end else if (sched_policy == POL_CSCAN) begin
            // nearest at or above the head; else wrap to the lowest block
            for (int i = 0; i < waiting_reqs.size(); i++) begin
                if (waiting_reqs[i].block >= shadow_head) begin
                    d = waiting_reqs[i].block - shadow_head;
                    if (!have_fwd || d < fd) begin
                        have_fwd = 1'b1;
                        fd       = d;
                        best     = i;
                    end
                end
                if (waiting_reqs[i].block < waiting_reqs[lo].block)
                    lo = i;
            end
            if (!have_fwd)
                best = lo;
        end
        return best;
    endfunction

    function automatic t_sched_result schedule_action(t_req_item it);
        t_sched_result       r;
        int                  k;
        logic [TRAVEL_W-1:0] hop;
        r        = '0;
        r.status = STAT_NOP;
        case (it.action)
            ACT_ENQ: begin
                if (waiting_reqs.size() >= QDEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    waiting_reqs.push_back('{block: it.block, wr: it.wr, tag: it.tag});
                    r.status = STAT_OK;
                end
            end
            ACT_DONE: begin
                if (disk_on) begin
                    r.completed     = 1'b1;
                    r.completed_tag = cur_tag;
                    disk_on         = 1'b0;
                    r.status        = STAT_OK;
                end
            end
            ACT_CLR: begin
                travel   = '0;
                r.status = STAT_OK;
            end
            default: ;
        endcase

        if (!disk_on && waiting_reqs.size() != 0) begin
            k             = pick_next();
            hop           = TRAVEL_W'(seek_dist(waiting_reqs[k].block, shadow_head));
            r.dispatched  = 1'b1;
            r.issue_block = waiting_reqs[k].block;
            r.issue_write = waiting_reqs[k].wr;
            r.issue_tag   = waiting_reqs[k].tag;
            if (TRAVEL_MAX - travel < hop)
                travel = TRAVEL_MAX;
            else
                travel = travel + hop;
            shadow_head = waiting_reqs[k].block;
            cur_tag     = waiting_reqs[k].tag;
            disk_on     = 1'b1;
            waiting_reqs.delete(k);
        end
        r.pending_count = CNT_W'(waiting_reqs.size());
        r.head_travel   = travel;
        return r;
    endfunction

    task automatic cmp_field(string name, longint unsigned want_v, longint unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: results are checked and transfers predicted at the rising
    // edge, on values settled since the falling edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_sched_result got;
        t_sched_result want;
        if (!i_rst_n) begin
            took_item = 1'b0;
        end else begin
            if (o_strobe) begin
                got = '{o_status, o_dispatched, o_issue_block, o_issue_write,
                        o_issue_tag, o_completed, o_completed_tag,
                        o_pending_count, o_head_travel};
                if (expected_outcomes.size() == 0) begin
                    $display("%0t: result with nothing outstanding: expected none, actual %p",
                             $time, got);
                    errors++;
                end else begin
                    want = expected_outcomes.pop_front();
                    cmp_field("status",        want.status,        got.status);
                    cmp_field("dispatched",    want.dispatched,    got.dispatched);
                    cmp_field("issue_block",   want.issue_block,   got.issue_block);
                    cmp_field("issue_write",   want.issue_write,   got.issue_write);
                    cmp_field("issue_tag",     want.issue_tag,     got.issue_tag);
                    cmp_field("completed",     want.completed,     got.completed);
                    cmp_field("completed_tag", want.completed_tag, got.completed_tag);
                    cmp_field("pending_count", want.pending_count, got.pending_count);
                    cmp_field("head_travel",   want.head_travel,   got.head_travel);
                end
            end
            if (i_cfg_we)
                sched_policy = t_policy'(i_cfg_wdata);
            took_item = start && !busy;
            if (took_item)
                expected_outcomes.push_back(
                    schedule_action('{i_action, i_block, i_write_op, i_tag}));
        end
    end

    // ------------------------------------------------------------------
    // Driver: moves to the next item only once the current transfer is
    // done; random idle gaps between items while idle_ok.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_req_item nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took_item) begin
            if (gap_left != 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (idle_ok && queued_actions.size() != 0 && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 5);   // this cycle is the first idle one
                start <= 1'b0;
            end else if (queued_actions.size() != 0) begin
                nxt = queued_actions.pop_front();
                i_action   <= nxt.action;
                i_block    <= nxt.block;
                i_write_op <= nxt.wr;
                i_tag      <= nxt.tag;
                start      <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_outcomes.size());
            $display("** disk_request_scheduler_core: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(logic [ACTION_W-1:0] act, logic [BLK_W-1:0] blk,
                             logic wr, logic [TAG_W-1:0] tg);
        queued_actions.push_back('{action: act, block: blk, wr: wr, tag: tg});
    endtask

    // Drain everything, then leave time for the last gap-closing pass.
    task automatic wait_quiet();
        while (queued_actions.size() != 0 || start || expected_outcomes.size() != 0 || busy)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_policy(t_policy p);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= p;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Runs of enqueue-heavy, done-heavy or mixed traffic so the table
    // swings between empty and full. Blocks are often drawn from a narrow
    // window so equal seek distances and repeated blocks come up.
    task automatic rand_items(int n);
        int                  run;
        int                  mode;
        int                  enq_pct;
        int                  roll;
        int                  sel;
        logic [ACTION_W-1:0] act;
        logic [BLK_W-1:0]    blk;
        run  = 0;
        mode = 0;
        repeat (n) begin
            if (run == 0) begin
                run  = $urandom_range(4, 20);
                mode = $urandom_range(0, 2);
            end
            run--;
            enq_pct = (mode == 1) ? 80 : (mode == 2) ? 15 : 45;
            roll    = $urandom_range(0, 99);
            if (roll < enq_pct)
                act = ACT_ENQ;
            else if (roll < 92)
                act = ACT_DONE;
            else if (roll < 97)
                act = ACT_CLR;
            else
                act = ACT_SPARE;
            sel = $urandom_range(0, 9);
            if (sel < 3)
                blk = BLK_W'(16'h7FFC + $urandom_range(0, 7));
            else if (sel == 3)
                blk = $urandom_range(0, 1) ? '1 : '0;
            else
                blk = BLK_W'($urandom_range(0, (1 << BLK_W) - 1));
            push_item(act, blk, 1'($urandom_range(0, 1)),
                      TAG_W'($urandom_range(0, (1 << TAG_W) - 1)));
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        t_policy phase_pol[8];
        phase_pol = '{POL_SSTF, POL_CSCAN, POL_ALT, POL_FCFS,
                      POL_CSCAN, POL_SSTF, POL_ALT, POL_CSCAN};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under FCFS
        set_policy(POL_FCFS);
        push_item(ACT_DONE,  '0, 1'b0, '0);        // done with the disk free
        push_item(ACT_SPARE, '1, 1'b1, '1);        // unused code, nothing pending
        push_item(ACT_ENQ,   '1, 1'b1, '1);        // dispatched at once, max seek
        for (int i = 0; i < QDEPTH; i++)           // fill the table while busy
            push_item(ACT_ENQ, BLK_W'(i * 16'h1111), i[0], 8'h80 ^ i[7:0]);
        push_item(ACT_ENQ,   16'h5A5A, 1'b0, 8'h00); // refused, table full
        push_item(ACT_DONE,  '0, 1'b0, '0);        // completes, next one issued
        push_item(ACT_SPARE, '0, 1'b0, '0);        // unused code while busy
        push_item(ACT_CLR,   '0, 1'b0, '0);        // travel total back to zero
        push_item(ACT_DONE,  '0, 1'b0, '0);
        wait_quiet();

        // Random phases, one policy each; requests carry over between them.
        // The last phase runs without input gaps.
        for (int p = 0; p < 8; p++) begin
            set_policy(phase_pol[p]);
            if (p == 7)
                idle_ok = 1'b0;
            rand_items(PHASE_ITEMS);
            wait_quiet();
        end

        if (errors == 0 && expected_outcomes.size() == 0) begin
            $display("** disk_request_scheduler_core: PASSED **");
        end else begin
            $display("** disk_request_scheduler_core: FAILED **");
        end
        $finish;
    end

endmodule

/* files.f */
sv/dsch_pkg.sv
sv/dsch_mem.sv
sv/dsch_pick.sv
sv/disk_request_scheduler_core.sv
tb/sv/tb_top.sv
